FILE: rtl/core/sphs_pkg.sv
// sphs_pkg: shared types and constants of the spectrum peak-hold statistics block
// used by sphs_divsqrt and spectrum_peak_hold_stats; depends on nothing else
`default_nettype none

package sphs_pkg;

  localparam int LEVEL_W  = 16;
  localparam int BIN_W    = 12;
  localparam int ALPHA_W  = 16;
  localparam int SUM_W    = 44;
  localparam int CNT_W    = 13;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BIN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BIN     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL_NEW,
    ST_MUL_OLD,
    ST_MUL_SQ,
    ST_UPDATE,
    ST_STATS,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    DS_IDLE,
    DS_DIV,
    DS_SQRT,
    DS_DONE
  } ds_state_e;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } ds_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ROOT_W-1:0] root;
  } ds_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/spectrum_peak_hold_stats.sv
// spectrum_peak_hold_stats: per-bin peak hold with decay and frame peak / rms report
// depends on sphs_pkg, sphs_ram, sphs_divsqrt
//
// usage
// - input channel (in_valid_i / in_stall_o): one spectrum bin word per handshake,
//   bin_value_i in Q0.16 and last_bin_i marking the frame's final bin
// - output channel (out_valid_o / out_stall_i): one result word per input word,
//   the bin index, the new held level, and on the last bin the frame report
// - config channel (cfg_valid_i / cfg_ready_o): decay_alpha, min_bin, max_bin by
//   index; always ready, writes meant to land only while the block is idle
// - sequencing: a new bin is taken only when the sequencer is back in idle; it runs the
//   read of the held store and three passes through the one shared 17x17 multiplier
// - the last bin of a frame adds the rms unit: a start, the bit-serial divide, the
//   square root and a done state; with no bin of the frame in range it adds only the
//   stats state, which skips the divider
// - reset: control and configuration registers return to defaults; the held store is not swept, a
//   high-water mark of written entries makes unwritten entries read as zero
// - a stalled result holds in the output register; the next bin is taken and
//   processed meanwhile, and waits before its result if the register is full
`default_nettype none

module spectrum_peak_hold_stats
  import sphs_pkg::*;
#(
  parameter int MAX_BINS = 4096
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // bin input
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [LEVEL_W-1:0]   bin_value_i,
  input  wire logic                 last_bin_i,
  // result output
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [BIN_W-1:0]     bin_index_o,
  output logic      [LEVEL_W-1:0]   held_level_o,
  output logic                      frame_done_o,
  output logic      [BIN_W-1:0]     peak_bin_o,
  output logic      [LEVEL_W-1:0]   peak_level_o,
  output logic      [LEVEL_W-1:0]   rms_level_o,
  // configuration writes
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [LEVEL_W-1:0]   cfg_data_i
);

  localparam int IDX_W = (MAX_BINS > 2) ? $clog2(MAX_BINS) : 1;
  localparam int CMP_W = (IDX_W > BIN_W) ? IDX_W : BIN_W;
  localparam int MUL_W = ALPHA_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BINS - 1);
  localparam logic [IDX_W:0]   FILL_MAX = (IDX_W + 1)'(MAX_BINS);
  localparam logic [MUL_W-1:0] ONE_Q16  = {1'b1, {ALPHA_W{1'b0}}};

  // configuration registers
  logic [ALPHA_W-1:0] alpha_q;
  logic [BIN_W-1:0]   min_bin_q;
  logic [BIN_W-1:0]   max_bin_q;

  // sequencer and frame state
  state_e             state_q, state_d;
  logic [IDX_W-1:0]   cnt_q;
  logic [IDX_W:0]     fill_q;
  logic [LEVEL_W-1:0] best_level_q;
  logic [BIN_W-1:0]   best_bin_q;
  logic [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]   count_q;
  logic               ds_started_q;

  // per-bin working registers
  logic [LEVEL_W-1:0] v_q;
  logic               last_q;
  logic [LEVEL_W-1:0] h_q;
  logic [31:0]        acc_q;
  logic [31:0]        sq_q;

  // output register
  logic               out_valid_q;
  logic [BIN_W-1:0]   out_idx_q;
  logic [LEVEL_W-1:0] out_held_q;
  logic               out_done_q;
  logic [BIN_W-1:0]   out_pbin_q;
  logic [LEVEL_W-1:0] out_plevel_q;
  logic [LEVEL_W-1:0] out_rms_q;

  logic               in_acc;
  logic               out_free;
  logic [LEVEL_W-1:0] rd_data;
  logic               rd_written;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] prod;
  logic [CMP_W-1:0]   idx_ext;
  logic               in_range;
  logic [SUM_W:0]     sum_add;
  logic [LEVEL_W-1:0] rms;
  ds_req_t            ds_req;
  ds_rsp_t            ds_rsp;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  // held store, read address follows the bin counter
  sphs_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (MAX_BINS)
  ) u_held_store (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_UPDATE),
    .waddr_i (cnt_q),
    .wdata_i (h_q),
    .raddr_i (cnt_q),
    .rdata_o (rd_data)
  );

  // entries at or above the high-water mark were never written since reset
  assign rd_written = ({1'b0, cnt_q} < fill_q);

  // shared multiplier: v*a, then h*(1-a), then v*v
  always_comb begin
    case (state_q)
      ST_MUL_NEW: begin
        mul_a = MUL_W'(v_q);
        mul_b = MUL_W'(alpha_q);
      end
      ST_MUL_OLD: begin
        mul_a = MUL_W'(h_q);
        mul_b = ONE_Q16 - MUL_W'(alpha_q);
      end
      default: begin
        mul_a = MUL_W'(v_q);
        mul_b = MUL_W'(v_q);
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign idx_ext  = CMP_W'(cnt_q);
  assign in_range = (idx_ext >= CMP_W'(min_bin_q)) && (idx_ext <= CMP_W'(max_bin_q));
  assign sum_add  = {1'b0, sum_q} + (SUM_W + 1)'(sq_q);

  // rms unit
  assign ds_req.start    = (state_q == ST_STATS) && !ds_started_q && (count_q != '0);
  assign ds_req.dividend = sum_q;
  assign ds_req.divisor  = count_q;

  sphs_divsqrt u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ds_req),
    .rsp_o  (ds_rsp)
  );

  always_comb begin
    if (count_q == '0) begin
      rms = '0;
    end else if (|ds_rsp.root[ROOT_W-1:LEVEL_W]) begin
      rms = {LEVEL_W{1'b1}};
    end else begin
      rms = ds_rsp.root[LEVEL_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_acc) state_d = ST_READ;
      ST_READ:    state_d = ST_MUL_NEW;
      ST_MUL_NEW: state_d = ST_MUL_OLD;
      ST_MUL_OLD: state_d = ST_MUL_SQ;
      ST_MUL_SQ:  state_d = ST_UPDATE;
      ST_UPDATE:  state_d = last_q ? ST_STATS : ST_EMIT;
      ST_STATS: begin
        // empty range skips the divider
        if (count_q == '0 || (ds_started_q && ds_rsp.done)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT:    if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      alpha_q      <= ALPHA_W'(655);
      min_bin_q    <= '0;
      max_bin_q    <= {BIN_W{1'b1}};
      cnt_q        <= '0;
      fill_q       <= '0;
      best_level_q <= '0;
      best_bin_q   <= '0;
      sum_q        <= '0;
      count_q      <= '0;
      ds_started_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_DECAY_ALPHA: alpha_q   <= cfg_data_i;
          CFG_MIN_BIN:     min_bin_q <= cfg_data_i[BIN_W-1:0];
          CFG_MAX_BIN:     max_bin_q <= cfg_data_i[BIN_W-1:0];
          default: ;
        endcase
      end

      if (state_q == ST_UPDATE) begin
        if (cnt_q == fill_q[IDX_W-1:0] && fill_q != FILL_MAX) begin
          fill_q <= fill_q + 1'b1;
        end
        if (in_range) begin
          // strict compare keeps the earlier bin on ties
          if (v_q > best_level_q) begin
            best_level_q <= v_q;
            best_bin_q   <= idx_ext[BIN_W-1:0];
          end
          sum_q <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
          if (count_q != COUNT_MAX) begin
            count_q <= count_q + 1'b1;
          end
        end
      end

      if (ds_req.start) begin
        ds_started_q <= 1'b1;
      end

      if (state_q == ST_EMIT && out_free) begin
        out_valid_q  <= 1'b1;
        ds_started_q <= 1'b0;
        if (last_q) begin
          cnt_q        <= '0;
          best_level_q <= '0;
          best_bin_q   <= '0;
          sum_q        <= '0;
          count_q      <= '0;
        end else begin
          cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + 1'b1;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      v_q    <= bin_value_i;
      last_q <= last_bin_i;
    end
    case (state_q)
      ST_READ:    h_q   <= rd_written ? rd_data : '0;
      ST_MUL_NEW: acc_q <= prod[31:0];
      ST_MUL_OLD: acc_q <= acc_q + prod[31:0];
      ST_MUL_SQ: begin
        sq_q <= prod[31:0];
        h_q  <= (v_q > h_q) ? v_q : acc_q[31:16];
      end
      default: ;
    endcase
    if (state_q == ST_EMIT && out_free) begin
      out_idx_q  <= idx_ext[BIN_W-1:0];
      out_held_q <= h_q;
      out_done_q <= last_q;
      if (last_q) begin
        out_pbin_q   <= (best_level_q != '0) ? best_bin_q : min_bin_q;
        out_plevel_q <= best_level_q;
        out_rms_q    <= rms;
      end else begin
        out_pbin_q   <= '0;
        out_plevel_q <= '0;
        out_rms_q    <= '0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign bin_index_o  = out_idx_q;
  assign held_level_o = out_held_q;
  assign frame_done_o = out_done_q;
  assign peak_bin_o   = out_pbin_q;
  assign peak_level_o = out_plevel_q;
  assign rms_level_o  = out_rms_q;

endmodule

`default_nettype wire

FILE: rtl/core/sphs_ram.sv
// sphs_ram: generic single-write, single-read RAM with registered read data
// depends on nothing
`default_nettype none

module sphs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/core/sphs_divsqrt.sv
// sphs_divsqrt: bit-serial restoring divide followed by digit-by-digit square root
// floor(sqrt(floor(dividend / divisor))); depends on sphs_pkg
`default_nettype none

module sphs_divsqrt
  import sphs_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire ds_req_t req_i,
  output ds_rsp_t      rsp_o
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  ds_state_e         state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  div_q, div_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [ROOT_W:0]   srem_q, srem_d;
  logic [ROOT_W-1:0] root_q, root_d;

  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_sub;
  logic [ROOT_W+2:0] srem_sh;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] srem_sub;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DS_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    srem_q <= srem_d;
    root_q <= root_d;
  end

  always_comb begin
    // one quotient bit per cycle
    rem_sh  = {rem_q, quo_q[SUM_W-1]};
    rem_sub = rem_sh - {1'b0, div_q};
    // one root bit per cycle, two radicand bits shifted in
    srem_sh  = {srem_q, quo_q[SUM_W-1 -: 2]};
    trial    = {1'b0, root_q, 2'b01};
    srem_sub = srem_sh - trial;

    state_d = state_q;
    step_d  = step_q;
    quo_d   = quo_q;
    div_d   = div_q;
    rem_d   = rem_q;
    srem_d  = srem_q;
    root_d  = root_q;

    case (state_q)
      DS_IDLE: begin
        if (req_i.start) begin
          quo_d   = req_i.dividend;
          div_d   = req_i.divisor;
          rem_d   = '0;
          step_d  = STEP_W'(SUM_W - 1);
          state_d = DS_DIV;
        end
      end
      DS_DIV: begin
        if (rem_sh >= {1'b0, div_q}) begin
          rem_d = rem_sub[CNT_W-1:0];
          quo_d = {quo_q[SUM_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[CNT_W-1:0];
          quo_d = {quo_q[SUM_W-2:0], 1'b0};
        end
        if (step_q == '0) begin
          srem_d  = '0;
          root_d  = '0;
          step_d  = STEP_W'(ROOT_W - 1);
          state_d = DS_SQRT;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      DS_SQRT: begin
        quo_d = {quo_q[SUM_W-3:0], 2'b00};
        if (srem_sh >= trial) begin
          srem_d = srem_sub[ROOT_W:0];
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          srem_d = srem_sh[ROOT_W:0];
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        if (step_q == '0) begin
          state_d = DS_DONE;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      DS_DONE: begin
        state_d = DS_IDLE;
      end
      default: begin
        state_d = DS_IDLE;
      end
    endcase
  end

  assign rsp_o.busy = (state_q != DS_IDLE);
  assign rsp_o.done = (state_q == DS_DONE);
  assign rsp_o.root = root_q;

endmodule

`default_nettype wire
